[hdl/soti_pkg.sv]
// shared types and constants of the set index lookup block
// no dependencies; compiled first

package soti_pkg;

    localparam int DATA_W    = 32;
    localparam int STEP_W    = 31;
    localparam int SIZE_W    = 33;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_FIND   = 2'd2,
        OP_AT     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_IN   = 2'd1,
        ST_OUT_OF_R = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    localparam logic [1:0] CFG_FIRST = 2'd0;
    localparam logic [1:0] CFG_LAST  = 2'd1;
    localparam logic [1:0] CFG_STEP  = 2'd2;

endpackage

[hdl/soti_if.sv]
// valid/ready channel interfaces for request and response transactions
// depends on soti_pkg

interface soti_in_if;
    logic                 valid;
    logic                 ready;
    soti_pkg::op_t        op;
    logic signed [31:0]   value_in;
    logic        [31:0]   index_in;

    modport source (output valid, op, value_in, index_in, input ready);
    modport sink   (input valid, op, value_in, index_in, output ready);
endinterface

interface soti_out_if;
    logic                 valid;
    logic                 ready;
    soti_pkg::status_t    status;
    logic        [31:0]   index_out;
    logic signed [31:0]   value_out;
    logic        [32:0]   set_size;

    modport source (output valid, status, index_out, value_out, set_size, input ready);
    modport sink   (input valid, status, index_out, value_out, set_size, output ready);
endinterface

[hdl/strided_or_table_set_index_lookup.sv]
// set index lookup: strided progression or sorted table held in a synchronous ram
// depends on soti_pkg and the channel interfaces in soti_if.sv
//
//  channel   dir   fields                                        transaction when
//  in_ch     in    op, value_in, index_in                        valid & ready
//  out_ch    out   status, index_out, value_out, set_size        valid & ready
//  cfg       in    cfg_we, cfg_index, cfg_data                   cfg_we high
//
//  one item at a time; clear, append and out-of-range requests go from idle through exec to response
//  progression finds run a radix-2 restoring divider; progression at requests multiply stride by index
//  the progression size is divided out once after a register write
//  table finds binary search the ram, each probe a read in S_SRCH and a compare in S_SCMP
//  reset is asynchronous; the ram needs no clearing pass, entries beyond the count are never read
//  a waiting response does not block the next request; the block stalls only in its response state

module strided_or_table_set_index_lookup #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    soti_in_if.sink     in_ch,
    soti_out_if.source  out_ch
);
    import soti_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // one-hot sequencer states
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_EXEC = 10'b00_0000_0010,
        S_SDIV = 10'b00_0000_0100,
        S_FDIV = 10'b00_0000_1000,
        S_SRCH = 10'b00_0001_0000,
        S_SCMP = 10'b00_0010_0000,
        S_ADD  = 10'b00_0100_0000,
        S_RDW  = 10'b00_1000_0000,
        S_RESP = 10'b01_0000_0000,
        S_SPARE_UNUSED = 10'b10_0000_0000
    } state_t;

    // configuration registers
    logic signed [DATA_W-1:0] first_value_reg;
    logic signed [DATA_W-1:0] last_value_reg;
    logic        [STEP_W-1:0] step_reg;

    // sequencer and table bookkeeping
    state_t                   state_reg;
    logic        [CW-1:0]     count_reg;
    logic                     size_ok_reg;
    logic        [SIZE_W-1:0] size_reg;
    logic        [DIV_CNT_W-1:0] div_cnt_reg;
    logic                     out_valid_reg;

    // payload of the current item and working values
    op_t                      op_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic        [DATA_W-1:0] idx_reg;
    logic signed [DATA_W-1:0] last_entry_reg;
    logic        [DATA_W-1:0] quo_reg;
    logic        [DATA_W-1:0] rem_reg;
    logic        [DATA_W-1:0] prod_reg;
    logic        [CW-1:0]     lo_ptr_reg;
    logic        [CW-1:0]     hi_ptr_reg;
    logic        [AW-1:0]     mid_reg;
    status_t                  res_status_reg;
    logic        [DATA_W-1:0] res_index_reg;
    logic signed [DATA_W-1:0] res_value_reg;

    // output register
    status_t                  out_status_reg;
    logic        [DATA_W-1:0] out_index_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic        [SIZE_W-1:0] out_size_reg;

    // table ram, one write and one registered read port
    logic        [DATA_W-1:0] table_entries [TABLE_DEPTH];
    logic        [DATA_W-1:0] mem_rdata_reg;
    logic                     mem_we;
    logic                     mem_re;
    logic        [AW-1:0]     mem_raddr;

    logic                     prog_mode;
    logic                     exec_go;
    logic                     append_ok;
    logic                     at_oor;
    logic                     resp_load;
    logic        [CW:0]       mid_sum;
    logic        [AW-1:0]     mid_addr;
    logic        [DATA_W-1:0] div_trial;
    logic                     div_fits;
    logic        [DATA_W-1:0] span;
    logic        [DATA_W-1:0] rel;

    assign prog_mode = (step_reg != '0);
    // progression size must be known before any item can finish
    assign exec_go   = (state_reg == S_EXEC) && (!prog_mode || size_ok_reg);
    assign append_ok = (count_reg != CW'(TABLE_DEPTH))
                       && ((count_reg == '0) || (value_reg > last_entry_reg));
    assign at_oor    = prog_mode ? ({1'b0, idx_reg} >= size_reg)
                                 : (idx_reg >= DATA_W'(count_reg));
    assign resp_load = (state_reg == S_RESP) && (!out_valid_reg || out_ch.ready);

    assign mid_sum   = {1'b0, lo_ptr_reg} + {1'b0, hi_ptr_reg};
    assign mid_addr  = AW'(mid_sum[CW:1]);

    assign span      = $unsigned(last_value_reg - first_value_reg);
    assign rel       = $unsigned(value_reg - first_value_reg);

    // one restoring division step; remainder stays below 2^31 so 32 bits hold the shift
    assign div_trial = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
    assign div_fits  = (div_trial >= {1'b0, step_reg});

    // ram controls
    assign mem_we = exec_go && (op_reg == OP_APPEND) && append_ok;
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = mid_addr;
        if (exec_go && (op_reg == OP_AT) && !prog_mode && !at_oor)
        begin
            mem_re    = 1'b1;
            mem_raddr = idx_reg[AW-1:0];
        end
        else if ((state_reg == S_SRCH) && (lo_ptr_reg < hi_ptr_reg))
        begin
            mem_re    = 1'b1;
            mem_raddr = mid_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_entries[count_reg[AW-1:0]] <= value_reg;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= table_entries[mem_raddr];
        end
    end

    // handshake ports
    assign in_ch.ready      = (state_reg == S_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.status    = out_status_reg;
    assign out_ch.index_out = out_index_reg;
    assign out_ch.value_out = out_value_reg;
    assign out_ch.set_size  = out_size_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_value_reg <= '0;
            last_value_reg  <= '0;
            step_reg        <= STEP_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST: first_value_reg <= cfg_data;
                CFG_LAST:  last_value_reg  <= cfg_data;
                CFG_STEP:  step_reg        <= cfg_data[STEP_W-1:0];
                default:   ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            size_ok_reg   <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new response replaces one taken in the same cycle
            if (resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // cached progression size goes stale on any register write
            if (cfg_we)
            begin
                size_ok_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (prog_mode && !size_ok_reg)
                    begin
                        if (last_value_reg < first_value_reg)
                        begin
                            size_ok_reg <= 1'b1;
                        end
                        else
                        begin
                            div_cnt_reg <= '0;
                            state_reg   <= S_SDIV;
                        end
                    end
                    else
                    begin
                        unique case (op_reg)
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                                state_reg <= S_RESP;
                            end
                            OP_APPEND:
                            begin
                                if (append_ok)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                                state_reg <= S_RESP;
                            end
                            OP_FIND:
                            begin
                                if (!prog_mode)
                                begin
                                    state_reg <= S_SRCH;
                                end
                                else if ((value_reg >= first_value_reg)
                                         && (value_reg <= last_value_reg))
                                begin
                                    div_cnt_reg <= '0;
                                    state_reg   <= S_FDIV;
                                end
                                else
                                begin
                                    state_reg <= S_RESP;
                                end
                            end
                            OP_AT:
                            begin
                                if (at_oor)
                                begin
                                    state_reg <= S_RESP;
                                end
                                else if (prog_mode)
                                begin
                                    state_reg <= S_ADD;
                                end
                                else
                                begin
                                    state_reg <= S_RDW;
                                end
                            end
                            default: state_reg <= S_RESP;
                        endcase
                    end
                end
                S_SDIV:
                begin
                    if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS))
                    begin
                        size_ok_reg <= 1'b1;
                        state_reg   <= S_EXEC;
                    end
                    else
                    begin
                        div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    end
                end
                S_FDIV:
                begin
                    if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS))
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    end
                end
                S_SRCH:
                begin
                    if (lo_ptr_reg < hi_ptr_reg)
                    begin
                        state_reg <= S_SCMP;
                    end
                    else
                    begin
                        state_reg <= S_RESP;
                    end
                end
                S_SCMP:
                begin
                    if ($signed(mem_rdata_reg) == value_reg)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_SRCH;
                    end
                end
                S_ADD:  state_reg <= S_RESP;
                S_RDW:  state_reg <= S_RESP;
                S_RESP:
                begin
                    if (resp_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg         <= in_ch.op;
            value_reg      <= in_ch.value_in;
            idx_reg        <= in_ch.index_in;
            res_status_reg <= ST_OK;
            res_index_reg  <= '0;
            res_value_reg  <= '0;
        end

        if (mem_we)
        begin
            last_entry_reg <= value_reg;
        end

        unique case (state_reg)
            S_EXEC:
            begin
                if (prog_mode && !size_ok_reg)
                begin
                    // empty progression, or load the span for the size division
                    size_reg <= '0;
                    quo_reg  <= span;
                    rem_reg  <= '0;
                end
                else
                begin
                    unique case (op_reg)
                        OP_APPEND:
                        begin
                            if (!append_ok)
                            begin
                                res_status_reg <= ST_REJECTED;
                            end
                        end
                        OP_FIND:
                        begin
                            res_status_reg <= ST_NOT_IN;
                            quo_reg        <= rel;
                            rem_reg        <= '0;
                            lo_ptr_reg     <= '0;
                            hi_ptr_reg     <= count_reg;
                        end
                        OP_AT:
                        begin
                            if (at_oor)
                            begin
                                res_status_reg <= ST_OUT_OF_R;
                            end
                            // low word of stride times index only
                            prod_reg <= DATA_W'({1'b0, step_reg} * idx_reg);
                        end
                        default: ;
                    endcase
                end
            end
            S_SDIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS))
                begin
                    size_reg <= {1'b0, quo_reg} + SIZE_W'(1);
                end
                else
                begin
                    rem_reg <= div_fits ? (div_trial - {1'b0, step_reg}) : div_trial;
                    quo_reg <= {quo_reg[DATA_W-2:0], div_fits};
                end
            end
            S_FDIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS))
                begin
                    if (rem_reg == '0)
                    begin
                        res_status_reg <= ST_OK;
                        res_index_reg  <= quo_reg;
                    end
                end
                else
                begin
                    rem_reg <= div_fits ? (div_trial - {1'b0, step_reg}) : div_trial;
                    quo_reg <= {quo_reg[DATA_W-2:0], div_fits};
                end
            end
            S_SRCH:
            begin
                mid_reg <= mid_addr;
            end
            S_SCMP:
            begin
                if ($signed(mem_rdata_reg) == value_reg)
                begin
                    res_status_reg <= ST_OK;
                    res_index_reg  <= DATA_W'(mid_reg);
                end
                else if ($signed(mem_rdata_reg) < value_reg)
                begin
                    lo_ptr_reg <= CW'(mid_reg) + CW'(1);
                end
                else
                begin
                    hi_ptr_reg <= CW'(mid_reg);
                end
            end
            S_ADD:
            begin
                res_value_reg <= first_value_reg + $signed(prod_reg);
            end
            S_RDW:
            begin
                res_value_reg <= mem_rdata_reg;
            end
            default: ;
        endcase

        if (resp_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_value_reg  <= res_value_reg;
            out_size_reg   <= prog_mode ? size_reg : SIZE_W'(count_reg);
        end
    end

`ifndef SYNTH
    // fill count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("table count beyond depth");

    // an accepted append grows the table by exactly one
    a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("append did not advance count");

    // divider never runs past its last step
    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SDIV) || (state_reg == S_FDIV))
        |-> (div_cnt_reg <= DIV_CNT_W'(DIV_STEPS)))
        else $error("divider step count overrun");

    // binary search window stays inside the filled part of the table
    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> ((lo_ptr_reg <= hi_ptr_reg) && (hi_ptr_reg <= count_reg)))
        else $error("search window out of table");

    // a response appears only after the response state
    a_resp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response without completed item");
`endif

endmodule

[sim/strided_or_table_set_index_lookup_tb.sv]
// self-checking testbench for the strided or table set index lookup block
// needs soti_pkg, the channel interfaces in soti_if.sv and the block itself
`timescale 1ns / 1ps

module strided_or_table_set_index_lookup_tb;

    import soti_pkg::*;

    localparam int LOOKUP_DEPTH = 256;

    typedef struct {
        status_t            status;
        logic        [31:0] index_out;
        logic signed [31:0] value_out;
        logic        [32:0] set_size;
    } lookup_result_t;

    // mirrors the set held by the block and queues the response due for each request
    class lookup_result_checker;
        logic signed [31:0] first_value_q;
        logic signed [31:0] last_value_q;
        logic        [30:0] stride_q;
        logic signed [31:0] table_mem [LOOKUP_DEPTH];
        int                 entry_count;
        lookup_result_t     pending_results [$];
        int                 error_count;
        int                 response_count;

        function new();
            first_value_q  = '0;
            last_value_q   = '0;
            stride_q       = 31'd1;
            entry_count    = 0;
            error_count    = 0;
            response_count = 0;
        endfunction

        function void set_config(logic signed [31:0] first_v, logic signed [31:0] last_v,
                                 logic [30:0] stride);
            first_value_q = first_v;
            last_value_q  = last_v;
            stride_q      = stride;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function logic [32:0] member_count();
            longint lo;
            longint hi;
            if (stride_q == 0)
                return 33'(entry_count);
            lo = first_value_q;
            hi = last_value_q;
            if (hi < lo)
                return '0;
            return 33'((hi - lo) / longint'(stride_q) + 1);
        endfunction

        function void note_request(op_t op, logic signed [31:0] value_in,
                                   logic [31:0] index_in);
            lookup_result_t     res;
            longint             v;
            longint             lo;
            longint             hi;
            longint             rel;
            longint unsigned    sum;
            res.status    = ST_OK;
            res.index_out = '0;
            res.value_out = '0;
            v = value_in;
            case (op)
                OP_CLEAR:
                    entry_count = 0;
                OP_APPEND:
                    if (entry_count >= LOOKUP_DEPTH ||
                        (entry_count > 0 && v <= longint'(table_mem[entry_count - 1])))
                        res.status = ST_REJECTED;
                    else
                    begin
                        table_mem[entry_count] = value_in;
                        entry_count++;
                    end
                OP_FIND:
                begin
                    res.status = ST_NOT_IN;
                    if (stride_q == 0)
                    begin
                        for (int i = 0; i < entry_count; i++)
                        begin
                            if (table_mem[i] == value_in)
                            begin
                                res.status    = ST_OK;
                                res.index_out = 32'(i);
                                break;
                            end
                        end
                    end
                    else
                    begin
                        lo = first_value_q;
                        hi = last_value_q;
                        if (v >= lo && v <= hi)
                        begin
                            rel = v - lo;
                            if (rel % longint'(stride_q) == 0)
                            begin
                                res.status    = ST_OK;
                                res.index_out = 32'(rel / longint'(stride_q));
                            end
                        end
                    end
                end
                OP_AT:
                    if ({1'b0, index_in} >= member_count())
                        res.status = ST_OUT_OF_R;
                    else if (stride_q == 0)
                        res.value_out = table_mem[index_in];
                    else
                    begin
                        sum = {32'd0, first_value_q} + {33'd0, stride_q} * {32'd0, index_in};
                        res.value_out = sum[31:0];
                    end
            endcase
            res.set_size = member_count();
            pending_results.insert(pending_results.size(), res);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            error_count++;
            if (error_count <= 40)
                $display("mismatch at response %0d: %s got %h expected %h",
                         response_count, what, got, want);
        endtask

        task check_response(status_t status, logic [31:0] index_out,
                            logic signed [31:0] value_out, logic [32:0] set_size);
            lookup_result_t want;
            response_count++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("response with no request outstanding", '0, '0);
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status)
                report_mismatch("status", status, want.status);
            if (index_out !== want.index_out)
                report_mismatch("index_out", index_out, want.index_out);
            if (value_out !== want.value_out)
                report_mismatch("value_out", value_out, want.value_out);
            if (set_size !== want.set_size)
                report_mismatch("set_size", set_size, want.set_size);
        endtask
    endclass

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 8;
    localparam int ITEM_TARGET  = 1800;
    // no transaction for this long means the block is stuck
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    // index 3 has no register behind it; writes to it must change nothing
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    soti_in_if  in_ch ();
    soti_out_if out_ch ();

    strided_or_table_set_index_lookup #(
        .TABLE_DEPTH (LOOKUP_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    lookup_result_checker lookup_chk;

    // when set, neither side inserts gaps (stretches at full rate)
    bit calm_phase = 1'b0;
    int sent_count = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // gap length for either side: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // sample both channels at the edge; values are the ones before this edge's updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                lookup_chk.note_request(in_ch.op, in_ch.value_in, in_ch.index_in);
            if (out_ch.valid && out_ch.ready)
                lookup_chk.check_response(out_ch.status, out_ch.index_out,
                                          out_ch.value_out, out_ch.set_size);
        end
    end

    // watchdog: counts edges with no transaction on either channel
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // response side: ready high for a run, then maybe low for a gap
    initial
    begin : response_stall
        int gap;
        out_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // one request transaction; valid stays high into the next one when there is no gap
    task automatic send_item(input op_t op, input logic signed [31:0] value,
                             input logic [31:0] index);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.op       <= op;
        in_ch.value_in <= value;
        in_ch.index_in <= index;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent_count++;
    endtask

    // drop valid and wait for every outstanding response
    task automatic settle();
        in_ch.valid <= 1'b0;
        // let the last accepted request be noted before looking at what is pending
        @(posedge clk);
        while (lookup_chk.pending() > 0)
            @(posedge clk);
    endtask

    // writes all registers while idle, plus a write to the unused index
    task automatic apply_config(input logic signed [31:0] first_v,
                                input logic signed [31:0] last_v,
                                input logic [30:0] stride);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST;
        cfg_data  <= first_v;
        @(posedge clk);
        cfg_index <= CFG_LAST;
        cfg_data  <= last_v;
        @(posedge clk);
        // bit 31 is beyond the stride register and must be dropped
        cfg_index <= CFG_STEP;
        cfg_data  <= {1'($urandom_range(0, 1)), stride};
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lookup_chk.set_config(first_v, last_v, stride);
    endtask

    // extremes of the fields and the corner cases of both set forms
    task automatic run_directed();
        // reset state: progression holding just zero
        send_item(OP_AT, $urandom, 32'd0);
        send_item(OP_AT, $urandom, 32'd1);
        send_item(OP_FIND, 32'sd0, $urandom);
        send_item(OP_FIND, -32'sd1, $urandom);
        send_item(OP_CLEAR, $urandom, $urandom);
        // append in progression mode still lands in the table
        send_item(OP_APPEND, 32'sd5, $urandom);

        // full 32-bit range, size of 2^32
        apply_config(INT_MIN, INT_MAX, 31'd1);
        send_item(OP_AT, $urandom, 32'hFFFF_FFFF);
        send_item(OP_FIND, INT_MAX, $urandom);
        send_item(OP_FIND, INT_MIN, $urandom);

        // largest stride, bound not reachable
        apply_config(INT_MIN, INT_MAX, 31'h7FFF_FFFF);
        send_item(OP_AT, $urandom, 32'd2);
        send_item(OP_AT, $urandom, 32'd3);
        send_item(OP_FIND, INT_MAX, $urandom);
        send_item(OP_FIND, -32'sd1, $urandom);

        // last below first: empty progression
        apply_config(32'sd10, -32'sd10, 31'd3);
        send_item(OP_AT, $urandom, 32'd0);
        send_item(OP_FIND, 32'sd10, $urandom);

        // table mode shows the entry appended earlier
        apply_config($urandom, $urandom, '0);
        send_item(OP_FIND, 32'sd5, $urandom);
        send_item(OP_APPEND, 32'sd3, $urandom);
        send_item(OP_CLEAR, $urandom, $urandom);
        send_item(OP_APPEND, INT_MIN, $urandom);
        send_item(OP_APPEND, INT_MIN, $urandom);
        send_item(OP_APPEND, INT_MAX, $urandom);
        send_item(OP_APPEND, 32'sd0, $urandom);
        send_item(OP_FIND, INT_MAX, $urandom);
        send_item(OP_AT, $urandom, 32'd1);
        send_item(OP_AT, $urandom, 32'd2);
        send_item(OP_AT, $urandom, 32'hFFFF_FFFF);
        send_item(OP_CLEAR, $urandom, $urandom);
    endtask

    // random progression, mostly small sizes, lookups near members and bounds
    task automatic run_progression_phase();
        logic signed [31:0] first_v;
        logic signed [31:0] v;
        logic        [30:0] stride;
        logic        [31:0] idx;
        longint             last_l;
        longint             sz;
        longint             k;
        longint             m;
        int                 n;
        int                 r;
        int                 c;
        op_t                op;
        case ($urandom_range(0, 9))
            0, 1, 2: stride = 31'd1;
            3, 4, 5: stride = 31'($urandom_range(2, 16));
            6, 7:    stride = 31'($urandom_range(17, 100000));
            8:       stride = 31'($urandom);
            default: stride = '1;
        endcase
        case ($urandom_range(0, 5))
            0:       first_v = INT_MIN;
            1:       first_v = INT_MAX;
            2:       first_v = $urandom_range(0, 200) - 100;
            default: first_v = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       last_l = longint'(first_v) - longint'($urandom_range(1, 1000));
            1:       last_l = INT_MAX;
            2, 3:
            begin
                v = $urandom;
                last_l = v;
            end
            default:
            begin
                last_l = longint'(first_v) + longint'($urandom_range(0, 40)) * longint'(stride);
                // push the bound off a member now and then
                if (stride > 1 && $urandom_range(0, 1) == 1)
                    last_l += longint'($urandom % stride);
            end
        endcase
        if (last_l > INT_MAX)
            last_l = INT_MAX;
        if (last_l < INT_MIN)
            last_l = INT_MIN;
        apply_config(first_v, 32'(last_l), stride);
        sz = lookup_chk.member_count();

        n = $urandom_range(15, 60);
        repeat (n)
        begin
            r   = $urandom_range(0, 99);
            c   = $urandom_range(0, 9);
            v   = $urandom;
            idx = $urandom;
            k   = (sz > 0) ? longint'($urandom) % sz : 0;
            m   = longint'(first_v) + k * longint'(stride);
            if (r < 40)
            begin
                op = OP_FIND;
                case (c)
                    0, 1, 2, 3, 4: v = 32'(m);
                    5:             v = 32'(m + 1);
                    6:             v = 32'(m - 1);
                    7:             v = 32'(last_l);
                    default:       ;
                endcase
            end
            else if (r < 80)
            begin
                op = OP_AT;
                case (c)
                    0, 1, 2, 3, 4, 5: idx = 32'(longint'($urandom) % (sz + 2));
                    6:                idx = 32'(sz);
                    7:                idx = 32'(sz - 1);
                    8:                idx = '1;
                    default:          ;
                endcase
            end
            else if (r < 90)
                op = OP_APPEND;
            else
                op = OP_CLEAR;
            send_item(op, v, idx);
        end
    endtask

    // table mode: mostly ascending appends, some out of order, lookups on members
    task automatic run_table_phase();
        logic signed [31:0] v;
        logic        [31:0] idx;
        longint             gen_last;
        longint             cand;
        int                 gen_count;
        int                 known;
        int                 spread;
        int                 n;
        int                 r;
        op_t                op;
        apply_config($urandom, $urandom, '0);
        gen_count = lookup_chk.entry_count;
        gen_last  = (gen_count > 0) ? longint'(lookup_chk.table_mem[gen_count - 1]) : 0;
        if ($urandom_range(0, 1) == 1)
        begin
            send_item(OP_CLEAR, $urandom, $urandom);
            gen_count = 0;
        end
        case ($urandom_range(0, 3))
            0:       spread = 3;
            1:       spread = 1000;
            2:       spread = 1 << 20;
            default: spread = 1 << 28;
        endcase
        n = $urandom_range(20, 80);
        repeat (n)
        begin
            r     = $urandom_range(0, 99);
            v     = $urandom;
            idx   = $urandom;
            // entries below this count are known to be written in the checker
            known = lookup_chk.entry_count;
            if (r < 45)
            begin
                op = OP_APPEND;
                if (gen_count == 0)
                    cand = ($urandom_range(0, 1) == 1) ?
                           longint'(INT_MIN) + longint'($urandom_range(0, 3)) : longint'(v);
                else if ($urandom_range(0, 9) == 0)
                    cand = gen_last - longint'($urandom_range(0, 2));
                else
                    cand = gen_last + longint'($urandom_range(1, spread));
                v = 32'(cand);
            end
            else if (r < 68)
            begin
                op = OP_FIND;
                if (known > 0 && $urandom_range(0, 9) < 7)
                begin
                    v = lookup_chk.table_mem[$urandom_range(0, known - 1)];
                    if ($urandom_range(0, 3) == 0)
                        v = v + 32'sd1;
                end
            end
            else if (r < 92)
            begin
                op = OP_AT;
                if ($urandom_range(0, 9) < 8)
                    idx = $urandom_range(0, gen_count + 1);
                else if ($urandom_range(0, 1) == 1)
                    idx = '1;
            end
            else if (r < 96)
                op = OP_CLEAR;
            else
                op = OP_APPEND;
            // track what the table will hold so appends stay mostly in order
            if (op == OP_CLEAR)
                gen_count = 0;
            else if (op == OP_APPEND && gen_count < LOOKUP_DEPTH &&
                     (gen_count == 0 || longint'(v) > gen_last))
            begin
                gen_last = v;
                gen_count++;
            end
            send_item(op, v, idx);
        end
    endtask

    // fills the table to its depth, then appends into the full table and looks up its entries
    task automatic run_fill_phase();
        longint gen_last;
        apply_config($urandom, $urandom, '0);
        send_item(OP_CLEAR, $urandom, $urandom);
        gen_last = longint'(INT_MIN) + longint'($urandom_range(0, 1000));
        for (int i = 0; i < LOOKUP_DEPTH + 3; i++)
        begin
            gen_last += longint'($urandom_range(1, 1000));
            send_item(OP_APPEND, 32'(gen_last), $urandom);
        end
        send_item(OP_AT, $urandom, LOOKUP_DEPTH - 1);
        send_item(OP_AT, $urandom, LOOKUP_DEPTH);
        send_item(OP_FIND, 32'(gen_last), $urandom);
        repeat (8)
            send_item(OP_FIND,
                      lookup_chk.table_mem[$urandom_range(0, lookup_chk.entry_count - 1)],
                      $urandom);
    endtask

    initial
    begin : stimulus
        int r;
        cfg_we         = 1'b0;
        cfg_index      = CFG_FIRST;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_CLEAR;
        in_ch.value_in = '0;
        in_ch.index_in = '0;
        lookup_chk     = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_fill_phase();
        while (sent_count < ITEM_TARGET)
        begin
            calm_phase = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 19);
            if (r == 0)
                run_fill_phase();
            else if (r < 10)
                run_table_phase();
            else
                run_progression_phase();
        end
        calm_phase = 1'b0;

        // everything sent: wait for the last responses, then let the block run on
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (lookup_chk.error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
